FILE: rtl/poct_pkg.sv
// Shared constants, command struct and gradient function for the octave noise block.
`default_nettype none

package poct_pkg;

    // Permutation table geometry.
    localparam int TABLE_SIZE = 256;
    localparam int TAB_AW     = $clog2(TABLE_SIZE);
    localparam int TAB_W      = 8;

    // Octave loop.
    localparam int MAX_OCTAVES = 8;
    localparam int OCT_W       = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int OCTCFG_W    = 4;

    // Coordinates: only the fraction and the low cell bits matter.
    localparam int COORD_W         = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int CK_W            = COORD_FRAC_BITS + TAB_AW;
    localparam int FRAC_W          = 16;

    // Amplitude and accumulation.
    localparam int PERS_W     = 16;
    localparam int PERS_FB    = 14;
    localparam int AMP_ONE_SH = 24;
    localparam int AMP_CAP_SH = 40;
    localparam int AMP_W      = AMP_CAP_SH + 1;
    localparam int AMP_LO_W   = 20;
    localparam int AMP_HI_W   = AMP_W - AMP_LO_W;
    localparam int WGT_W      = AMP_W + OCT_W + 1;
    localparam int ACC_W      = 64;

    // Gradient, lerp and noise value widths.
    localparam int CRD_W  = FRAC_W + 2;
    localparam int GRAD_W = 20;
    localparam int LO_W   = 22;
    localparam int NV_W   = 24;

    // Restoring divider and output.
    localparam int DIV_STEPS = 20;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int OUT_W     = 18;

    // Per-octave sequencer step counter.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

    // Input command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERSIST = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              start;
        logic              oct_setup;
        logic              run;
        logic [STEP_W-1:0] step;
        logic [OCT_W-1:0]  oct;
        logic              div_init;
        logic              div_step;
        logic              out_load;
    } t_dp_cmd;

    // Improved Perlin gradient for the z = 0 plane.
    function automatic logic signed [GRAD_W-1:0] grad(
        input logic [3:0]             h,
        input logic signed [CRD_W-1:0] x,
        input logic signed [CRD_W-1:0] y
    );
        logic signed [GRAD_W-1:0] u;
        logic signed [GRAD_W-1:0] v;
        u = (h[3] == 1'b0) ? GRAD_W'(x) : GRAD_W'(y);
        if (h[3:2] == 2'b00) begin
            v = GRAD_W'(y);
        end else if (h == 4'd12 || h == 4'd14) begin
            v = GRAD_W'(x);
        end else begin
            v = '0;
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/perlin_octave_noise_2d.sv
// Top level of the 2D octave Perlin noise block.
`default_nettype none

// A load beat (cmd 0) writes one permutation entry directly on the input beat and
// leaves the block ready; all 256 entries must be loaded before the first evaluate.
// An evaluate beat (cmd 1) runs the octaves in turn: each octave needs ten dependent
// lookups through the single read port of the permutation RAM plus gradient, lerp and
// weighting steps, and the weighted sum is then divided by the weight total in a
// bit-serial restoring divider. One evaluate is in flight at a time; the next beat is
// taken while a finished result still waits in the output register. The user must
// write configuration through the cfg channel only while the block is idle; the block
// does not enforce this. The cfg channel is always ready.
module perlin_octave_noise_2d import poct_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_cmd,
    input  wire logic [TAB_AW-1:0]         i_table_index,
    input  wire logic [TAB_W-1:0]          i_table_value,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [OUT_W-1:0]        o_noise_value,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_W-1:0]          i_cfg_data
);

    logic [OCTCFG_W-1:0] r_octave_count;
    logic [PERS_W-1:0]   r_persistence;
    t_dp_cmd             dp_cmd;
    logic [TAB_AW-1:0]   raddr;
    logic [TAB_W-1:0]    rdata;
    logic                load_we;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= OCTCFG_W'(4);
            r_persistence  <= PERS_W'(8192);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_OCTAVES) begin
                r_octave_count <= i_cfg_data[OCTCFG_W-1:0];
            end else if (i_cfg_index == REG_PERSIST) begin
                r_persistence <= i_cfg_data[PERS_W-1:0];
            end
        end
    end

    // Table loads write the RAM directly on the input beat.
    assign load_we = i_valid && o_ready && (i_cmd == CMD_LOAD);

    poct_ram #(
        .WIDTH (TAB_W),
        .DEPTH (TABLE_SIZE)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_table_index),
        .i_wdata (i_table_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    poct_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_cmd       (i_cmd),
        .o_in_ready     (o_ready),
        .o_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_octave_count (r_octave_count),
        .o_cmd          (dp_cmd)
    );

    poct_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (dp_cmd),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_persistence (r_persistence),
        .o_raddr       (raddr),
        .i_rdata       (rdata),
        .o_noise_value (o_noise_value)
    );

endmodule

`default_nettype wire

FILE: rtl/poct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module poct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/poct_ctrl.sv
// Controller state machine that sequences octaves, table reads and the divider.
`default_nettype none

module poct_ctrl import poct_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_cmd,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire logic [OCTCFG_W-1:0] i_octave_count,
    output t_dp_cmd                  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_DIV_INIT,
        S_DIV,
        S_FIN
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic [OCT_W-1:0]  r_oct;
    logic [OCT_W-1:0]  r_oct_last;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_out_valid;

    logic              eval_beat;
    logic              out_load;
    logic [OCT_W-1:0]  oct_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign eval_beat  = i_in_valid && o_in_ready && (i_in_cmd == CMD_EVAL);
    assign out_load   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    // Clamp the octave count to one through the maximum, kept as a last index.
    always_comb begin
        if (i_octave_count == '0) begin
            oct_last = '0;
        end else if ({1'b0, i_octave_count} > (OCTCFG_W + 1)'(MAX_OCTAVES)) begin
            oct_last = OCT_W'(MAX_OCTAVES - 1);
        end else begin
            oct_last = OCT_W'(i_octave_count - 1'b1);
        end
    end

    // State, counters and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_oct       <= '0;
            r_oct_last  <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (eval_beat) begin
                        r_state    <= S_SETUP;
                        r_oct      <= '0;
                        r_oct_last <= oct_last;
                    end
                end
                S_SETUP: begin
                    r_state <= S_RUN;
                    r_step  <= '0;
                end
                S_RUN: begin
                    if (r_step == STEP_LAST) begin
                        if (r_oct == r_oct_last) begin
                            r_state <= S_DIV_INIT;
                        end else begin
                            r_oct   <= r_oct + 1'b1;
                            r_state <= S_SETUP;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DIV_INIT: begin
                    r_state <= S_DIV;
                    r_dcnt  <= '0;
                end
                S_DIV: begin
                    if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    // Commands to the datapath.
    always_comb begin
        o_cmd.start     = eval_beat;
        o_cmd.oct_setup = (r_state == S_SETUP);
        o_cmd.run       = (r_state == S_RUN);
        o_cmd.step      = r_step;
        o_cmd.oct       = r_oct;
        o_cmd.div_init  = (r_state == S_DIV_INIT);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.out_load  = out_load;
    end

endmodule

`default_nettype wire

FILE: rtl/poct_dp.sv
// Datapath: coordinate split, fade, table hashing, lerps, weighting and division.
`default_nettype none

module poct_dp import poct_pkg::*; (
    input  wire logic                      i_clk,
    input  wire t_dp_cmd                   i_cmd,
    input  wire logic signed [COORD_W-1:0] i_coord_x,
    input  wire logic signed [COORD_W-1:0] i_coord_y,
    input  wire logic [PERS_W-1:0]         i_persistence,
    output logic [TAB_AW-1:0]              o_raddr,
    input  wire logic [TAB_W-1:0]          i_rdata,
    output logic signed [OUT_W-1:0]        o_noise_value
);

    // Step numbers of the per-octave sequence.
    localparam logic [STEP_W-1:0] STEP_GRAD  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_LERP1 = 4'd12;
    localparam logic [STEP_W-1:0] STEP_LERP2 = 4'd13;
    localparam logic [STEP_W-1:0] STEP_MUL   = 4'd14;

    localparam int Q_W = DIV_STEPS;

    // Sample coordinates, cell and fraction of the current octave.
    logic [CK_W-1:0]   r_cx, r_cy;
    logic [TAB_AW-1:0] r_xi, r_yi;
    logic [FRAC_W-1:0] r_xf, r_yf;

    // Fade pipeline.
    logic [FRAC_W-1:0]        r_tt_x, r_tt_y, r_t3_x, r_t3_y;
    logic signed [21:0]       r_at_x, r_at_y, r_bb_x, r_bb_y;
    logic [FRAC_W:0]          r_u, r_v;

    // Hashing.
    logic [TAB_W-1:0] r_a, r_b, r_ta, r_ta1, r_tb, r_tb1;
    logic [TAB_W-1:0] r_haa, r_hab, r_hba, r_hbb;

    // Gradients, lerps, products and sums.
    logic signed [GRAD_W-1:0] r_g00, r_g10, r_g01, r_g11;
    logic signed [LO_W-1:0]   r_lo, r_hi;
    logic signed [NV_W-1:0]   r_nv;
    logic signed [NV_W+AMP_LO_W:0] r_plo;
    logic signed [NV_W+AMP_HI_W:0] r_phi;
    logic signed [ACC_W-1:0]  r_total;
    logic [WGT_W-1:0]         r_weight;
    logic [AMP_W-1:0]         r_amp;

    // Divider.
    logic             r_neg;
    logic [ACC_W-1:0] r_rem, r_dvs;
    logic [Q_W-1:0]   r_q;
    logic signed [OUT_W-1:0] r_noise;

    logic [CK_W-1:0]          xs, ys;
    logic [CK_W+FRAC_W-1:0]   xe, ye;
    logic signed [CRD_W-1:0]  x0, y0, x1, y1;
    logic signed [20:0]       a_x, a_y;
    logic signed [38:0]       at_px, at_py;
    logic [36:0]              fd_px, fd_py;
    logic signed [LO_W:0]     d_lo, d_hi;
    logic signed [LO_W+FRAC_W+2:0] m_lo, m_hi;
    logic signed [LO_W+1:0]   d_nv;
    logic signed [LO_W+FRAC_W+3:0] m_nv;
    logic [AMP_W+PERS_W-1:0]  amp_prod;
    logic [AMP_W+PERS_W-PERS_FB-1:0] amp_sh;
    logic [AMP_W-1:0]         amp_next;
    logic signed [Q_W:0]      q_signed;

    // Scale by the octave and split into cell and Q0.16 fraction.
    assign xs = r_cx << i_cmd.oct;
    assign ys = r_cy << i_cmd.oct;
    assign xe = {xs, {FRAC_W{1'b0}}};
    assign ye = {ys, {FRAC_W{1'b0}}};

    // Corner offsets.
    assign x0 = CRD_W'({1'b0, r_xf});
    assign y0 = CRD_W'({1'b0, r_yf});
    assign x1 = x0 - CRD_W'(1 << FRAC_W);
    assign y1 = y0 - CRD_W'(1 << FRAC_W);

    // Fade polynomial terms.
    assign a_x   = 21'(6 * {1'b0, r_xf}) - 21'(15 << FRAC_W);
    assign a_y   = 21'(6 * {1'b0, r_yf}) - 21'(15 << FRAC_W);
    assign at_px = a_x * $signed({1'b0, r_xf});
    assign at_py = a_y * $signed({1'b0, r_yf});
    assign fd_px = 37'(r_t3_x) * 37'(r_bb_x[20:0]);
    assign fd_py = 37'(r_t3_y) * 37'(r_bb_y[20:0]);

    // Lerp terms.
    assign d_lo = (LO_W + 1)'(r_g10) - (LO_W + 1)'(r_g00);
    assign d_hi = (LO_W + 1)'(r_g11) - (LO_W + 1)'(r_g01);
    assign m_lo = d_lo * $signed({1'b0, r_u});
    assign m_hi = d_hi * $signed({1'b0, r_u});
    assign d_nv = (LO_W + 2)'(r_hi) - (LO_W + 2)'(r_lo);
    assign m_nv = d_nv * $signed({1'b0, r_v});

    // Next amplitude, capped.
    assign amp_prod = (AMP_W + PERS_W)'(r_amp) * (AMP_W + PERS_W)'(i_persistence);
    assign amp_sh   = amp_prod[AMP_W+PERS_W-1:PERS_FB];
    assign amp_next = (amp_sh > (AMP_W + PERS_W - PERS_FB)'(1) << AMP_CAP_SH)
                    ? AMP_W'(1) << AMP_CAP_SH : amp_sh[AMP_W-1:0];

    // Table read address for each step.
    always_comb begin
        case (i_cmd.step)
            4'd0:    o_raddr = r_xi;
            4'd1:    o_raddr = r_xi + 1'b1;
            4'd2:    o_raddr = r_a;
            4'd3:    o_raddr = r_a + 1'b1;
            4'd4:    o_raddr = r_b;
            4'd5:    o_raddr = r_b + 1'b1;
            4'd6:    o_raddr = r_ta;
            4'd7:    o_raddr = r_ta1;
            4'd8:    o_raddr = r_tb;
            4'd9:    o_raddr = r_tb1;
            default: o_raddr = r_xi;
        endcase
    end

    // Fade pipeline runs freely; the fraction holds for a whole octave.
    always_ff @(posedge i_clk) begin
        r_tt_x <= FRAC_W'((32'(r_xf) * 32'(r_xf)) >> FRAC_W);
        r_tt_y <= FRAC_W'((32'(r_yf) * 32'(r_yf)) >> FRAC_W);
        r_at_x <= 22'(at_px >>> FRAC_W);
        r_at_y <= 22'(at_py >>> FRAC_W);
        r_t3_x <= FRAC_W'((32'(r_tt_x) * 32'(r_xf)) >> FRAC_W);
        r_t3_y <= FRAC_W'((32'(r_tt_y) * 32'(r_yf)) >> FRAC_W);
        r_bb_x <= r_at_x + 22'(10 << FRAC_W);
        r_bb_y <= r_at_y + 22'(10 << FRAC_W);
        r_u    <= (FRAC_W + 1)'(fd_px >> FRAC_W);
        r_v    <= (FRAC_W + 1)'(fd_py >> FRAC_W);
    end

    // Evaluation start and octave setup.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cx     <= i_coord_x[CK_W-1:0];
            r_cy     <= i_coord_y[CK_W-1:0];
            r_total  <= '0;
            r_weight <= '0;
            r_amp    <= AMP_W'(1) << AMP_ONE_SH;
        end
        if (i_cmd.oct_setup) begin
            r_xi <= xs[CK_W-1:COORD_FRAC_BITS];
            r_yi <= ys[CK_W-1:COORD_FRAC_BITS];
            r_xf <= xe[COORD_FRAC_BITS+FRAC_W-1:COORD_FRAC_BITS];
            r_yf <= ye[COORD_FRAC_BITS+FRAC_W-1:COORD_FRAC_BITS];
        end
        // Per-octave step sequence.
        if (i_cmd.run) begin
            case (i_cmd.step)
                4'd1:  r_a   <= i_rdata + r_yi;
                4'd2:  r_b   <= i_rdata + r_yi;
                4'd3:  r_ta  <= i_rdata;
                4'd4:  r_ta1 <= i_rdata;
                4'd5:  r_tb  <= i_rdata;
                4'd6:  r_tb1 <= i_rdata;
                4'd7:  r_haa <= i_rdata;
                4'd8:  r_hab <= i_rdata;
                4'd9:  r_hba <= i_rdata;
                4'd10: r_hbb <= i_rdata;
                STEP_GRAD: begin
                    r_g00 <= grad(r_haa[3:0], x0, y0);
                    r_g10 <= grad(r_hba[3:0], x1, y0);
                    r_g01 <= grad(r_hab[3:0], x0, y1);
                    r_g11 <= grad(r_hbb[3:0], x1, y1);
                end
                STEP_LERP1: begin
                    r_lo <= LO_W'(r_g00) + LO_W'(m_lo >>> FRAC_W);
                    r_hi <= LO_W'(r_g01) + LO_W'(m_hi >>> FRAC_W);
                end
                STEP_LERP2: begin
                    r_nv <= NV_W'(r_lo) + NV_W'(m_nv >>> FRAC_W);
                end
                STEP_MUL: begin
                    r_plo <= r_nv * $signed({1'b0, r_amp[AMP_LO_W-1:0]});
                    r_phi <= r_nv * $signed({1'b0, r_amp[AMP_W-1:AMP_LO_W]});
                end
                STEP_LAST: begin
                    r_total  <= r_total + ACC_W'(r_plo) + (ACC_W'(r_phi) <<< AMP_LO_W);
                    r_weight <= r_weight + WGT_W'(r_amp);
                    r_amp    <= amp_next;
                end
                default: begin
                end
            endcase
        end
    end

    // Restoring divider on magnitudes, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_neg <= r_total[ACC_W-1];
            r_rem <= r_total[ACC_W-1] ? ACC_W'(-r_total) : ACC_W'(r_total);
            r_dvs <= ACC_W'(r_weight) << (DIV_STEPS - 1);
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_dvs) begin
                r_rem <= r_rem - r_dvs;
                r_q   <= {r_q[Q_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[Q_W-2:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
        end
    end

    // Apply the sign and saturate into the output register.
    assign q_signed = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (q_signed > (Q_W + 1)'((1 << (OUT_W - 1)) - 1)) begin
                r_noise <= OUT_W'((1 << (OUT_W - 1)) - 1);
            end else if (q_signed < -(Q_W + 1)'(1 << (OUT_W - 1))) begin
                r_noise <= OUT_W'(1 << (OUT_W - 1));
            end else begin
                r_noise <= OUT_W'(q_signed);
            end
        end
    end

    assign o_noise_value = r_noise;

endmodule

`default_nettype wire

FILE: rtl/poct_chk.sv
// Port-level checker for the octave noise block, bound to the top level.
`default_nettype none

module poct_chk import poct_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_ready,
    input wire logic                      i_cmd,
    input wire logic [TAB_AW-1:0]         i_table_index,
    input wire logic [TAB_W-1:0]          i_table_value,
    input wire logic signed [COORD_W-1:0] i_coord_x,
    input wire logic signed [COORD_W-1:0] i_coord_y,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic signed [OUT_W-1:0]   o_noise_value,
    input wire logic                      i_cfg_valid,
    input wire logic                      o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input wire logic [CFG_W-1:0]          i_cfg_data
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_noise_value))
        else $error("result changed while stalled");

    // An evaluate beat occupies the block on the next cycle.
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_cmd == CMD_EVAL |=> !o_ready && !$rose(o_valid))
        else $error("evaluate beat did not start a computation");

    // A load beat leaves the block ready and produces no result.
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_cmd == CMD_LOAD |=> o_ready && !$rose(o_valid))
        else $error("load beat disturbed the block");

endmodule

bind perlin_octave_noise_2d poct_chk u_poct_chk (.*);

`default_nettype wire
